[rtl/core/bse_pkg.sv]
// ----------------------------------------------------------------------------
// Bytecode stack executor package
// Shared widths, opcodes, status codes and the microcode table that steers
// the datapath of the executor.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int DATA_W      = 32;
    localparam int CMD_W       = 8;
    localparam int IMM_W       = 8;
    localparam int DEPTH_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int ITER_W      = $clog2(DATA_W);

    // Request payload bit positions.
    localparam int CMD_LSB     = 0;
    localparam int IMM_LSB     = CMD_LSB + CMD_W;
    localparam int IN_W        = ((IMM_LSB + IMM_W + 7) / 8) * 8;

    // Result payload bit positions.
    localparam int TOP_LSB     = 0;
    localparam int DEPTH_LSB   = TOP_LSB + DATA_W;
    localparam int STATUS_LSB  = DEPTH_LSB + DEPTH_W;
    localparam int OUT_W       = ((STATUS_LSB + STATUS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] OP_PUSH = 8'd16;
    localparam logic [CMD_W-1:0] OP_ADD  = 8'd96;
    localparam logic [CMD_W-1:0] OP_MUL  = 8'd104;
    localparam logic [CMD_W-1:0] OP_REM  = 8'd112;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // Datapath action selected by a control word.
    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_DECODE,
        UOP_PUSH,
        UOP_LOAD,
        UOP_ADD,
        UOP_MUL,
        UOP_REM_INIT,
        UOP_REM_STEP,
        UOP_REM_FIX,
        UOP_WRITE,
        UOP_EMIT
    } uop_t;

    // Sequencing rule of a control word.
    typedef enum logic [2:0] {
        JMP_ALWAYS,
        JMP_ACCEPT,
        JMP_OUT_FREE,
        JMP_ITER,
        JMP_DISPATCH,
        JMP_OPSEL
    } jmp_t;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t A_IDLE     = 4'd0;
    localparam upc_t A_DECODE   = 4'd1;
    localparam upc_t A_PUSH     = 4'd2;
    localparam upc_t A_LOAD     = 4'd3;
    localparam upc_t A_ADD      = 4'd4;
    localparam upc_t A_MUL      = 4'd5;
    localparam upc_t A_REM_INIT = 4'd6;
    localparam upc_t A_REM_STEP = 4'd7;
    localparam upc_t A_REM_FIX  = 4'd8;
    localparam upc_t A_WRITE    = 4'd9;
    localparam upc_t A_EMIT     = 4'd10;

    // tgt is taken when the jump condition holds, alt otherwise.
    typedef struct packed {
        uop_t uop;
        jmp_t jmp;
        upc_t tgt;
        upc_t alt;
    } ucw_t;

    function automatic ucw_t ucode_rom(input upc_t addr);
        ucw_t w;
        case (addr)
            A_IDLE:     w = '{uop: UOP_IDLE,     jmp: JMP_ACCEPT,   tgt: A_DECODE,   alt: A_IDLE};
            A_DECODE:   w = '{uop: UOP_DECODE,   jmp: JMP_DISPATCH, tgt: A_EMIT,     alt: A_EMIT};
            A_PUSH:     w = '{uop: UOP_PUSH,     jmp: JMP_ALWAYS,   tgt: A_EMIT,     alt: A_EMIT};
            A_LOAD:     w = '{uop: UOP_LOAD,     jmp: JMP_OPSEL,    tgt: A_ADD,      alt: A_ADD};
            A_ADD:      w = '{uop: UOP_ADD,      jmp: JMP_ALWAYS,   tgt: A_WRITE,    alt: A_WRITE};
            A_MUL:      w = '{uop: UOP_MUL,      jmp: JMP_ALWAYS,   tgt: A_WRITE,    alt: A_WRITE};
            A_REM_INIT: w = '{uop: UOP_REM_INIT, jmp: JMP_ALWAYS,   tgt: A_REM_STEP, alt: A_REM_STEP};
            A_REM_STEP: w = '{uop: UOP_REM_STEP, jmp: JMP_ITER,     tgt: A_REM_STEP, alt: A_REM_FIX};
            A_REM_FIX:  w = '{uop: UOP_REM_FIX,  jmp: JMP_ALWAYS,   tgt: A_WRITE,    alt: A_WRITE};
            A_WRITE:    w = '{uop: UOP_WRITE,    jmp: JMP_ALWAYS,   tgt: A_EMIT,     alt: A_EMIT};
            A_EMIT:     w = '{uop: UOP_EMIT,     jmp: JMP_OUT_FREE, tgt: A_IDLE,     alt: A_EMIT};
            default:    w = '{uop: UOP_IDLE,     jmp: JMP_ALWAYS,   tgt: A_IDLE,     alt: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/bse_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/bytecode_stack_executor.sv]
// ----------------------------------------------------------------------------
// Bytecode stack executor
// Runs push, add, multiply and remainder bytecodes on a 32-entry stack of
// 32-bit integers under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each request runs from decode to the output step: errors and ignored
// opcodes go there at once, push through the push step, add and multiply
// through load, operate and write, remainder through load, a loop of one
// quotient bit a cycle that sets the worst case, fix and write. A new request
// is taken while the previous result still waits in the output register.
// Reset empties the stack at once; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
module bytecode_stack_executor
    import bse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // command[7:0], immediate[15:8]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // top_value[31:0], depth[37:32], status[39:38]
);

    // Control state
    upc_t            upc_reg, upc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [IMM_W-1:0] imm_reg, imm_next;
    logic [DATA_W-1:0]       top_reg, top_next;
    logic [DATA_W-1:0]       a_reg, a_next;
    logic [DATA_W-1:0]       b_reg, b_next;
    logic [DATA_W-1:0]       res_reg, res_next;
    logic [DATA_W-1:0]       rem_reg, rem_next;
    logic [DATA_W-1:0]       dvd_reg, dvd_next;
    logic [DATA_W-1:0]       dvs_reg, dvs_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    status_t                 status_reg, status_next;
    logic [OUT_W-1:0]        out_data_reg, out_data_next;

    ucw_t              ucw;
    logic              accept;
    logic              out_free;
    logic              is_arith;
    upc_t              disp_tgt;
    status_t           disp_status;
    upc_t              opsel_tgt;
    logic [CNT_W-1:0]  cnt_m2;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] product;
    logic [DATA_W-1:0] top_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    bse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_m2[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready = (upc_reg == A_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ucw      = ucode_rom(upc_reg);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign product  = a_reg * b_reg;
    assign trial    = {rem_reg, dvd_reg[DATA_W-1]} - {1'b0, dvs_reg};
    assign top_out  = (count_reg == '0) ? '0 : top_reg;
    assign is_arith = (cmd_reg == OP_ADD) || (cmd_reg == OP_MUL) || (cmd_reg == OP_REM);

    // Decode step: pick the path and the status of the current request. The
    // top of stack is cached in top_reg, so the divisor check needs no read.
    always_comb
    begin
        disp_tgt    = A_EMIT;
        disp_status = ST_OK;
        if (cmd_reg == OP_PUSH)
        begin
            if (count_reg == CNT_W'(STACK_DEPTH))
            begin
                disp_status = ST_OVER;
            end
            else
            begin
                disp_tgt = A_PUSH;
            end
        end
        else if (is_arith)
        begin
            if (count_reg < CNT_W'(2))
            begin
                disp_status = ST_UNDER;
            end
            else if ((cmd_reg == OP_REM) && (top_reg == '0))
            begin
                disp_status = ST_DIVZ;
            end
            else
            begin
                disp_tgt = A_LOAD;
            end
        end
    end

    always_comb
    begin
        case (cmd_reg)
            OP_ADD:  opsel_tgt = A_ADD;
            OP_MUL:  opsel_tgt = A_MUL;
            default: opsel_tgt = A_REM_INIT;
        endcase
    end

    // Datapath driven by the current control word.
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd_next       = cmd_reg;
        imm_next       = imm_reg;
        top_next       = top_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        iter_next      = iter_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_wdata      = res_reg;

        case (ucw.uop)
            UOP_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = s_tdata[CMD_LSB +: CMD_W];
                    imm_next = s_tdata[IMM_LSB +: IMM_W];
                end
            end
            UOP_DECODE:
            begin
                status_next = disp_status;
            end
            UOP_PUSH:
            begin
                top_next   = {{(DATA_W-IMM_W){imm_reg[IMM_W-1]}}, imm_reg};
                ram_we     = 1'b1;
                ram_waddr  = count_reg[ADDR_W-1:0];
                ram_wdata  = {{(DATA_W-IMM_W){imm_reg[IMM_W-1]}}, imm_reg};
                count_next = count_reg + CNT_W'(1);
            end
            UOP_LOAD:
            begin
                a_next = ram_rdata;
                b_next = top_reg;
            end
            UOP_ADD:
            begin
                res_next = a_reg + b_reg;
            end
            UOP_MUL:
            begin
                res_next = product;
            end
            UOP_REM_INIT:
            begin
                dvd_next  = a_reg[DATA_W-1] ? (DATA_W'(0) - a_reg) : a_reg;
                dvs_next  = b_reg[DATA_W-1] ? (DATA_W'(0) - b_reg) : b_reg;
                rem_next  = '0;
                iter_next = '1;
            end
            UOP_REM_STEP:
            begin
                // Restoring division on magnitudes, one bit per cycle.
                if (!trial[DATA_W])
                begin
                    rem_next = trial[DATA_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[DATA_W-2:0], dvd_reg[DATA_W-1]};
                end
                dvd_next  = {dvd_reg[DATA_W-2:0], 1'b0};
                iter_next = iter_reg - ITER_W'(1);
            end
            UOP_REM_FIX:
            begin
                // The remainder takes the sign of the dividend.
                res_next = a_reg[DATA_W-1] ? (DATA_W'(0) - rem_reg) : rem_reg;
            end
            UOP_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_m2[ADDR_W-1:0];
                ram_wdata  = res_reg;
                top_next   = res_reg;
                count_next = count_reg - CNT_W'(1);
            end
            UOP_EMIT:
            begin
                if (out_free)
                begin
                    out_data_next  = '0;
                    out_data_next[TOP_LSB +: DATA_W]      = top_out;
                    out_data_next[DEPTH_LSB +: DEPTH_W]   = DEPTH_W'(count_reg);
                    out_data_next[STATUS_LSB +: STATUS_W] = status_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer: next step from the control word's jump rule.
    always_comb
    begin
        case (ucw.jmp)
            JMP_ALWAYS:   upc_next = ucw.tgt;
            JMP_ACCEPT:   upc_next = accept ? ucw.tgt : ucw.alt;
            JMP_OUT_FREE: upc_next = out_free ? ucw.tgt : ucw.alt;
            JMP_ITER:     upc_next = (iter_reg != '0) ? ucw.tgt : ucw.alt;
            JMP_DISPATCH: upc_next = disp_tgt;
            JMP_OPSEL:    upc_next = opsel_tgt;
            default:      upc_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        imm_reg      <= imm_next;
        top_reg      <= top_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        iter_reg     <= iter_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/core/bse_checker.sv]
// ----------------------------------------------------------------------------
// Bytecode stack executor checker
// Port-level properties of the executor, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker
    import bse_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Overflow is only reported on a full stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STATUS_LSB +: STATUS_W] == ST_OVER)
        |-> (m_tdata[DEPTH_LSB +: DEPTH_W] == DEPTH_W'(STACK_DEPTH)))
        else $error("overflow reported below full depth");

    // Underflow is only reported with fewer than two entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STATUS_LSB +: STATUS_W] == ST_UNDER)
        |-> (m_tdata[DEPTH_LSB +: DEPTH_W] < DEPTH_W'(2)))
        else $error("underflow reported with two or more entries");

    // An empty stack shows a zero top value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[DEPTH_LSB +: DEPTH_W] == '0)
        |-> (m_tdata[TOP_LSB +: DATA_W] == '0))
        else $error("non-zero top value on an empty stack");

endmodule

bind bytecode_stack_executor bse_checker u_bse_checker (.*);
